### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the core.
// Depends on nothing; included by the bound checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset disable
`define CLCL_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error("clcl check failed");

// Signal holds in the cycle after cond
`define CLCL_ASSERT_STABLE(lbl, clk_s, rst_s, cond, sig) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond) |=> $stable(sig)) \
        else $error("clcl hold check failed");

`endif

### rtl/core/clcl_pkg.sv
// Types, widths, register map and reset values of the current limit duty loop.
// No dependencies; used by every other file of the core but assert_macros.svh.
package clcl_pkg;

    localparam int ADC_BITS       = 12;
    localparam int DUTY_FRAC_BITS = 16;

    localparam int DUTY_W      = DUTY_FRAC_BITS + 1;
    localparam int CUR_W       = 21;
    localparam int GAIN_W      = 20;
    localparam int LOOP_GAIN_W = 16;
    localparam int PWM_W       = 10;

    localparam int SCALE_PROD_W = ADC_BITS + GAIN_W;
    localparam int SCALE_SHIFT  = 8;
    localparam int ERR_PROD_W   = CUR_W + LOOP_GAIN_W;
    localparam int ERR_SHIFT    = 32 - DUTY_FRAC_BITS;
    localparam int STEP_W       = ERR_PROD_W - ERR_SHIFT + 1;
    localparam int SUM_W        = STEP_W + 1;
    localparam int PWM_PROD_W   = PWM_W + DUTY_W + 1;

    localparam logic [CUR_W-1:0]  CUR_MAX  = {CUR_W{1'b1}};
    localparam logic [DUTY_W-1:0] DUTY_ONE = DUTY_W'(1) << DUTY_FRAC_BITS;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    typedef enum logic [2:0] {
        REG_TARGET_CURRENT = 3'd0,
        REG_RAW_GAIN       = 3'd1,
        REG_AMP_GAIN       = 3'd2,
        REG_RAW_CODE_LIMIT = 3'd3,
        REG_AMP_CODE_LIMIT = 3'd4,
        REG_LOOP_GAIN      = 3'd5,
        REG_PWM_RANGE      = 3'd6
    } reg_idx_t;

    localparam logic [CUR_W-1:0]       RST_TARGET_CURRENT = CUR_W'(27525);
    localparam logic [GAIN_W-1:0]      RST_RAW_GAIN       = GAIN_W'(96575);
    localparam logic [GAIN_W-1:0]      RST_AMP_GAIN       = GAIN_W'(21245);
    localparam logic [ADC_BITS-1:0]    RST_RAW_CODE_LIMIT = ADC_BITS'(620);
    localparam logic [ADC_BITS-1:0]    RST_AMP_CODE_LIMIT = ADC_BITS'(3722);
    localparam logic [LOOP_GAIN_W-1:0] RST_LOOP_GAIN      = LOOP_GAIN_W'(6554);
    localparam logic [PWM_W-1:0]       RST_PWM_RANGE      = PWM_W'(250);

    typedef struct packed {
        logic [CUR_W-1:0]       target_current;
        logic [GAIN_W-1:0]      raw_gain;
        logic [GAIN_W-1:0]      amp_gain;
        logic [ADC_BITS-1:0]    raw_code_limit;
        logic [ADC_BITS-1:0]    amp_code_limit;
        logic [LOOP_GAIN_W-1:0] loop_gain;
        logic [PWM_W-1:0]       pwm_range;
    } cfg_t;

    typedef struct packed {
        logic [CUR_W-1:0] raw_current;
        logic [CUR_W-1:0] amp_current;
        logic             used_amplified;
    } sample_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DUTY,
        BK_PWM
    } back_state_t;

endpackage

### rtl/core/clcl_if.sv
// Valid/ready channel interfaces for sense samples and loop results.
// Depends on clcl_pkg.
interface clcl_in_if import clcl_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] raw_code;
    logic [ADC_BITS-1:0] amp_code;

    modport source (output valid, output raw_code, output amp_code, input ready);
    modport sink (input valid, input raw_code, input amp_code, output ready);
endinterface

interface clcl_out_if import clcl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PWM_W-1:0]  pwm_count;
    logic              direction;
    logic [DUTY_W-1:0] duty_level;
    logic [CUR_W-1:0]  raw_current;
    logic [CUR_W-1:0]  amp_current;
    logic              used_amplified;

    modport source (output valid, output pwm_count, output direction, output duty_level,
                    output raw_current, output amp_current, output used_amplified,
                    input ready);
    modport sink (input valid, input pwm_count, input direction, input duty_level,
                  input raw_current, input amp_current, input used_amplified,
                  output ready);
endinterface

### rtl/core/clcl_front.sv
// Front end: accepts sense samples, scales both codes to current, picks the path.
// Depends on clcl_pkg and clcl_in_if.
module clcl_front import clcl_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    clcl_in_if.sink       in_ch,
    input  cfg_t          cfg,
    input  queue_status_t q_status,
    output logic          push,
    output sample_t       push_data
);

    logic                busy_reg;
    logic                busy_next;
    logic [ADC_BITS-1:0] raw_code_reg;
    logic [ADC_BITS-1:0] raw_code_next;
    logic [ADC_BITS-1:0] amp_code_reg;
    logic [ADC_BITS-1:0] amp_code_next;

    function automatic logic [CUR_W-1:0] scale_current(
        input logic [ADC_BITS-1:0] code,
        input logic [GAIN_W-1:0]   gain
    );
        logic [SCALE_PROD_W-1:0] prod;
        logic [SCALE_PROD_W:0]   rnd;
        logic [SCALE_PROD_W-SCALE_SHIFT:0] shifted;
        prod    = SCALE_PROD_W'(code) * SCALE_PROD_W'(gain);
        rnd     = {1'b0, prod} + (SCALE_PROD_W + 1)'(1 << (SCALE_SHIFT - 1));
        shifted = rnd[SCALE_PROD_W:SCALE_SHIFT];
        if (shifted > (SCALE_PROD_W - SCALE_SHIFT + 1)'(CUR_MAX))
            return CUR_MAX;
        else
            return shifted[CUR_W-1:0];
    endfunction

    assign in_ch.ready = !busy_reg;
    assign push        = busy_reg && !q_status.full;

    always_comb
    begin
        push_data.raw_current    = scale_current(raw_code_reg, cfg.raw_gain);
        push_data.amp_current    = scale_current(amp_code_reg, cfg.amp_gain);
        push_data.used_amplified = (raw_code_reg <= cfg.raw_code_limit)
                                   && (amp_code_reg <= cfg.amp_code_limit);
    end

    always_comb
    begin
        busy_next     = busy_reg;
        raw_code_next = raw_code_reg;
        amp_code_next = amp_code_reg;
        if (in_ch.valid && in_ch.ready)
        begin
            busy_next     = 1'b1;
            raw_code_next = in_ch.raw_code;
            amp_code_next = in_ch.amp_code;
        end
        else if (push)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        raw_code_reg <= raw_code_next;
        amp_code_reg <= amp_code_next;
    end

endmodule

### rtl/core/clcl_queue.sv
// Two-entry queue of scaled samples between front and back end.
// Depends on clcl_pkg.
module clcl_queue import clcl_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sample_t       push_data,
    input  logic          pop,
    output sample_t       pop_data,
    output queue_status_t status
);

    sample_t     entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = !wr_ptr_reg;
        if (pop)
            rd_ptr_next = !rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/core/clcl_back.sv
// Back end: error, loop gain multiply, duty integration and PWM count.
// Depends on clcl_pkg and clcl_out_if.
module clcl_back import clcl_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  queue_status_t q_status,
    input  sample_t       pop_data,
    output logic          pop,
    clcl_out_if.source    out_ch
);

    back_state_t             state_reg;
    back_state_t             state_next;
    logic [DUTY_W-1:0]       duty_reg;
    logic [DUTY_W-1:0]       duty_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;

    sample_t                 entry_reg;
    sample_t                 entry_next;
    sample_t                 held_reg;
    sample_t                 held_next;
    logic                    neg_reg;
    logic                    neg_next;
    logic [CUR_W-1:0]        err_reg;
    logic [CUR_W-1:0]        err_next;
    logic [ERR_PROD_W-1:0]   prod_reg;
    logic [ERR_PROD_W-1:0]   prod_next;
    logic [PWM_W-1:0]        pwm_reg;
    logic [PWM_W-1:0]        pwm_next;
    logic [DUTY_W-1:0]       level_reg;
    logic [DUTY_W-1:0]       level_next;

    logic [CUR_W-1:0]        cur;
    logic [ERR_PROD_W:0]     prod_rnd;
    logic [STEP_W-1:0]       step;
    logic [SUM_W-1:0]        duty_ext;
    logic [SUM_W-1:0]        step_ext;
    logic [SUM_W-1:0]        duty_sum;
    logic [PWM_PROD_W-1:0]   pwm_prod;
    logic                    out_free;

    assign out_free = !out_valid_reg || out_ch.ready;

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.pwm_count      = pwm_reg;
    assign out_ch.direction      = (level_reg != '0);
    assign out_ch.duty_level     = level_reg;
    assign out_ch.raw_current    = entry_reg.raw_current;
    assign out_ch.amp_current    = entry_reg.amp_current;
    assign out_ch.used_amplified = entry_reg.used_amplified;

    always_comb
    begin
        state_next     = state_reg;
        duty_next      = duty_reg;
        out_valid_next = out_valid_reg;
        entry_next     = entry_reg;
        neg_next       = neg_reg;
        err_next       = err_reg;
        prod_next      = prod_reg;
        pwm_next       = pwm_reg;
        level_next     = level_reg;
        pop            = 1'b0;

        cur      = pop_data.used_amplified ? pop_data.amp_current : pop_data.raw_current;
        prod_rnd = {1'b0, prod_reg} + (ERR_PROD_W + 1)'(1 << (ERR_SHIFT - 1));
        step     = prod_rnd[ERR_PROD_W:ERR_SHIFT];
        duty_ext = SUM_W'(duty_reg);
        step_ext = SUM_W'(step);
        if (neg_reg)
            duty_sum = (step_ext >= duty_ext) ? '0 : duty_ext - step_ext;
        else
            duty_sum = duty_ext + step_ext;
        pwm_prod = PWM_PROD_W'(cfg.pwm_range) * PWM_PROD_W'(duty_reg)
                   + PWM_PROD_W'(1 << (DUTY_FRAC_BITS - 1));

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty && out_free)
                begin
                    pop        = 1'b1;
                    neg_next   = cur > cfg.target_current;
                    err_next   = (cur > cfg.target_current) ? cur - cfg.target_current
                                                            : cfg.target_current - cur;
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                prod_next  = ERR_PROD_W'(err_reg) * ERR_PROD_W'(cfg.loop_gain);
                state_next = BK_DUTY;
            end
            BK_DUTY:
            begin
                if (duty_sum > SUM_W'(DUTY_ONE))
                    duty_next = DUTY_ONE;
                else
                    duty_next = duty_sum[DUTY_W-1:0];
                state_next = BK_PWM;
            end
            BK_PWM:
            begin
                if (out_free)
                begin
                    entry_next     = held_reg;
                    pwm_next       = pwm_prod[DUTY_FRAC_BITS +: PWM_W];
                    level_next     = duty_reg;
                    out_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // hold the popped sample until the result is written
    always_comb
    begin
        held_next = held_reg;
        if (pop)
            held_next = pop_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            duty_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            duty_reg      <= duty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        held_reg  <= held_next;
        neg_reg   <= neg_next;
        err_reg   <= err_next;
        prod_reg  <= prod_next;
        pwm_reg   <= pwm_next;
        level_reg <= level_next;
    end

endmodule

### rtl/core/current_limit_duty_loop_core.sv
// Top level of the current limit duty loop: APB register file, front, queue, back.
// Depends on clcl_pkg, clcl_if, clcl_front, clcl_queue and clcl_back.
//
//   channel   dir   handshake       payload
//   in_ch     in    valid/ready     raw_code, amp_code
//   out_ch    out   valid/ready     pwm_count, direction, duty_level,
//                                   raw_current, amp_current, used_amplified
//   apb       in    psel/penable    paddr, pwdata, prdata (pready tied high)
//
// Front captures an item, then scales both codes and pushes it; it takes no new item
// until that push, which waits while the queue is full. Back steps through select and
// error, loop gain multiply, duty update and PWM multiply, and takes no new item until
// the last result is in the output register; it sets the sustained rate.
// Reset clears the duty store, the queue and all valid flags; registers take defaults.
// A stalled output holds in the output register; the back end waits before popping.
module current_limit_duty_loop_core import clcl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    clcl_in_if.sink           in_ch,
    clcl_out_if.source        out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t          cfg_reg;
    cfg_t          cfg_next;
    reg_idx_t      reg_idx;
    logic          wr_en;
    logic          push;
    logic          pop;
    sample_t       push_data;
    sample_t       pop_data;
    queue_status_t q_status;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_TARGET_CURRENT: cfg_next.target_current = pwdata[CUR_W-1:0];
                REG_RAW_GAIN:       cfg_next.raw_gain       = pwdata[GAIN_W-1:0];
                REG_AMP_GAIN:       cfg_next.amp_gain       = pwdata[GAIN_W-1:0];
                REG_RAW_CODE_LIMIT: cfg_next.raw_code_limit = pwdata[ADC_BITS-1:0];
                REG_AMP_CODE_LIMIT: cfg_next.amp_code_limit = pwdata[ADC_BITS-1:0];
                REG_LOOP_GAIN:      cfg_next.loop_gain      = pwdata[LOOP_GAIN_W-1:0];
                REG_PWM_RANGE:      cfg_next.pwm_range      = pwdata[PWM_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TARGET_CURRENT: prdata = APB_DW'(cfg_reg.target_current);
            REG_RAW_GAIN:       prdata = APB_DW'(cfg_reg.raw_gain);
            REG_AMP_GAIN:       prdata = APB_DW'(cfg_reg.amp_gain);
            REG_RAW_CODE_LIMIT: prdata = APB_DW'(cfg_reg.raw_code_limit);
            REG_AMP_CODE_LIMIT: prdata = APB_DW'(cfg_reg.amp_code_limit);
            REG_LOOP_GAIN:      prdata = APB_DW'(cfg_reg.loop_gain);
            REG_PWM_RANGE:      prdata = APB_DW'(cfg_reg.pwm_range);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_current <= RST_TARGET_CURRENT;
            cfg_reg.raw_gain       <= RST_RAW_GAIN;
            cfg_reg.amp_gain       <= RST_AMP_GAIN;
            cfg_reg.raw_code_limit <= RST_RAW_CODE_LIMIT;
            cfg_reg.amp_code_limit <= RST_AMP_CODE_LIMIT;
            cfg_reg.loop_gain      <= RST_LOOP_GAIN;
            cfg_reg.pwm_range      <= RST_PWM_RANGE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    clcl_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    clcl_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    clcl_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .pop_data (pop_data),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule

### rtl/core/clcl_checker.sv
// Port-level checks on the result channel of the current limit duty loop.
// Depends on clcl_pkg and assert_macros.svh; bound to the top level.
`include "assert_macros.svh"

module clcl_checker import clcl_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [PWM_W-1:0]  pwm_count,
    input logic              direction,
    input logic [DUTY_W-1:0] duty_level,
    input logic [CUR_W-1:0]  raw_current,
    input logic [CUR_W-1:0]  amp_current,
    input logic              used_amplified
);

    logic [PWM_W+DUTY_W+2*CUR_W+1:0] out_data;

    assign out_data = {pwm_count, direction, duty_level, raw_current, amp_current,
                       used_amplified};

    `CLCL_ASSERT(out_valid_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
    `CLCL_ASSERT_STABLE(out_data_hold, clk, rst_n, out_valid && !out_ready, out_data)
    `CLCL_ASSERT(duty_in_range, clk, rst_n, out_valid |-> duty_level <= DUTY_ONE)
    `CLCL_ASSERT(dir_matches_duty, clk, rst_n, out_valid |-> direction == (duty_level != '0))
    `CLCL_ASSERT(pwm_zero_at_zero_duty, clk, rst_n, out_valid && duty_level == '0 |-> pwm_count == '0)

endmodule

bind current_limit_duty_loop_core clcl_checker u_clcl_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .pwm_count      (out_ch.pwm_count),
    .direction      (out_ch.direction),
    .duty_level     (out_ch.duty_level),
    .raw_current    (out_ch.raw_current),
    .amp_current    (out_ch.amp_current),
    .used_amplified (out_ch.used_amplified)
);

### sim/tb_current_limit_duty_loop_core.sv
// Self-checking testbench for current_limit_duty_loop_core: APB register setup, sense items in,
// loop results out, checked against an in-bench duty loop tracker under varied stalls.
// Depends on clcl_pkg, clcl_if and the core RTL.
module tb_current_limit_duty_loop_core;
    import clcl_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 10;
    localparam int SEGMENTS     = 9;
    localparam int SEG_ITEMS    = 72;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int CODE_MAX     = (1 << ADC_BITS) - 1;
    localparam logic [2:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic [PWM_W-1:0]  pwm_count;
        logic              direction;
        logic [DUTY_W-1:0] duty_level;
        logic [CUR_W-1:0]  raw_current;
        logic [CUR_W-1:0]  amp_current;
        logic              used_amplified;
    } tick_result_t;

    class duty_loop_tracker;
        logic [CUR_W-1:0]       target_current;
        logic [GAIN_W-1:0]      raw_gain;
        logic [GAIN_W-1:0]      amp_gain;
        logic [ADC_BITS-1:0]    raw_code_limit;
        logic [ADC_BITS-1:0]    amp_code_limit;
        logic [LOOP_GAIN_W-1:0] loop_gain;
        logic [PWM_W-1:0]       pwm_range;
        logic [DUTY_W-1:0]      duty;
        tick_result_t           pending_ticks[$];
        int                     errors;
        int                     checked;
        int                     amp_ticks;

        function new();
            target_current = RST_TARGET_CURRENT;
            raw_gain       = RST_RAW_GAIN;
            amp_gain       = RST_AMP_GAIN;
            raw_code_limit = RST_RAW_CODE_LIMIT;
            amp_code_limit = RST_AMP_CODE_LIMIT;
            loop_gain      = RST_LOOP_GAIN;
            pwm_range      = RST_PWM_RANGE;
            duty           = '0;
            errors         = 0;
            checked        = 0;
            amp_ticks      = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_TARGET_CURRENT: target_current = value[CUR_W-1:0];
                REG_RAW_GAIN:       raw_gain       = value[GAIN_W-1:0];
                REG_AMP_GAIN:       amp_gain       = value[GAIN_W-1:0];
                REG_RAW_CODE_LIMIT: raw_code_limit = value[ADC_BITS-1:0];
                REG_AMP_CODE_LIMIT: amp_code_limit = value[ADC_BITS-1:0];
                REG_LOOP_GAIN:      loop_gain      = value[LOOP_GAIN_W-1:0];
                REG_PWM_RANGE:      pwm_range      = value[PWM_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [CUR_W-1:0] amperes(logic [ADC_BITS-1:0] code, logic [GAIN_W-1:0] gain);
            logic [63:0] v;
            v = (64'(code) * 64'(gain) + 64'd128) >> 8;
            return (v > 64'(CUR_MAX)) ? CUR_MAX : v[CUR_W-1:0];
        endfunction

        function void note_sample(logic [ADC_BITS-1:0] rc, logic [ADC_BITS-1:0] ac);
            logic [CUR_W-1:0] rcur;
            logic [CUR_W-1:0] acur;
            logic [CUR_W-1:0] cur;
            logic             use_amp;
            logic             over;
            logic [63:0]      err;
            logic [63:0]      step;
            logic [63:0]      next_duty;
            logic [63:0]      pwm;
            tick_result_t     t;
            rcur    = amperes(rc, raw_gain);
            acur    = amperes(ac, amp_gain);
            use_amp = (rc <= raw_code_limit) && (ac <= amp_code_limit);
            cur     = use_amp ? acur : rcur;
            over    = cur > target_current;
            err     = over ? 64'(cur) - 64'(target_current) : 64'(target_current) - 64'(cur);
            step    = (err * 64'(loop_gain) + (64'd1 << (ERR_SHIFT - 1))) >> ERR_SHIFT;
            if (over)
                next_duty = (step >= 64'(duty)) ? 64'd0 : 64'(duty) - step;
            else
                next_duty = 64'(duty) + step;
            if (next_duty > 64'(DUTY_ONE))
                next_duty = 64'(DUTY_ONE);
            duty = next_duty[DUTY_W-1:0];
            pwm  = (64'(pwm_range) * next_duty + (64'd1 << (DUTY_FRAC_BITS - 1)))
                   >> DUTY_FRAC_BITS;
            t.pwm_count      = pwm[PWM_W-1:0];
            t.direction      = (next_duty != 64'd0);
            t.duty_level     = duty;
            t.raw_current    = rcur;
            t.amp_current    = acur;
            t.used_amplified = use_amp;
            pending_ticks.insert(pending_ticks.size(), t);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_tick(tick_result_t got);
            tick_result_t want;
            if (pending_ticks.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = pending_ticks.pop_front();
            checked++;
            if (want.used_amplified)
                amp_ticks++;
            compare_field("pwm_count", want.pwm_count, got.pwm_count);
            compare_field("direction", want.direction, got.direction);
            compare_field("duty_level", want.duty_level, got.duty_level);
            compare_field("raw_current", want.raw_current, got.raw_current);
            compare_field("amp_current", want.amp_current, got.amp_current);
            compare_field("used_amplified", want.used_amplified, got.used_amplified);
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int send_idle;
    int recv_idle;
    int cycles;
    int settings;

    duty_loop_tracker tracker = new();

    clcl_in_if  sense_if ();
    clcl_out_if result_if ();

    current_limit_duty_loop_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (sense_if),
        .out_ch  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial clk = 1'b0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_if.ready = rst_n && ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
            tracker.check_tick('{result_if.pwm_count, result_if.direction,
                                 result_if.duty_level, result_if.raw_current,
                                 result_if.amp_current, result_if.used_amplified});
    end

    function automatic logic [ADC_BITS-1:0] near_limit(logic [ADC_BITS-1:0] lim);
        int v;
        v = int'(lim) + int'($urandom_range(40)) - 20;
        if (v < 0)
            v = 0;
        if (v > CODE_MAX)
            v = CODE_MAX;
        return v[ADC_BITS-1:0];
    endfunction

    function automatic logic [31:0] pick(logic [31:0] hi);
        case ($urandom_range(3))
            0: return 32'd0;
            1: return hi;
            default: return $urandom_range(hi);
        endcase
    endfunction

    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        tracker.set_reg(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic settle();
        sense_if.valid = 1'b0;
        while (tracker.pending_ticks.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic configure(logic [31:0] tc, logic [31:0] rg, logic [31:0] ag,
                             logic [31:0] rl, logic [31:0] al, logic [31:0] lg,
                             logic [31:0] pr);
        settle();
        apb_write(REG_TARGET_CURRENT, tc);
        apb_write(REG_RAW_GAIN, rg);
        apb_write(REG_AMP_GAIN, ag);
        apb_write(REG_RAW_CODE_LIMIT, rl);
        apb_write(REG_AMP_CODE_LIMIT, al);
        apb_write(REG_LOOP_GAIN, lg);
        apb_write(REG_PWM_RANGE, pr);
        settings++;
    endtask

    task automatic send_sample(logic [ADC_BITS-1:0] rc, logic [ADC_BITS-1:0] ac);
        while ($urandom_range(99) < send_idle)
        begin
            sense_if.valid = 1'b0;
            @(negedge clk);
        end
        sense_if.valid    = 1'b1;
        sense_if.raw_code = rc;
        sense_if.amp_code = ac;
        @(posedge clk);
        while (!sense_if.ready)
            @(posedge clk);
        tracker.note_sample(rc, ac);
        @(negedge clk);
    endtask

    task automatic send_random();
        if ($urandom_range(3) == 0)
            send_sample($urandom_range(CODE_MAX), $urandom_range(CODE_MAX));
        else
            send_sample(near_limit(tracker.raw_code_limit), near_limit(tracker.amp_code_limit));
    endtask

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        sense_if.valid    = 1'b0;
        sense_if.raw_code = '0;
        sense_if.amp_code = '0;
        send_idle         = 36;
        recv_idle         = 76;
        cycles            = 0;
        settings          = 1;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_sample(0, 0);
        send_sample(RST_RAW_CODE_LIMIT, RST_AMP_CODE_LIMIT);
        send_sample(RST_RAW_CODE_LIMIT + 1, RST_AMP_CODE_LIMIT);
        send_sample(RST_RAW_CODE_LIMIT, RST_AMP_CODE_LIMIT + 1);
        send_sample(CODE_MAX, CODE_MAX);
        send_sample(CODE_MAX, 0);
        send_sample(0, CODE_MAX);
        send_sample(2048, 1000);

        configure(CUR_MAX, 32'hF_FFFF, 32'hF_FFFF, CODE_MAX, CODE_MAX, 32'hFFFF, 1023);
        apb_write(REG_SPARE, 32'hFFFF_FFFF);
        send_sample(CODE_MAX, CODE_MAX);
        send_sample(0, 0);
        send_sample(0, 0);
        send_sample(1, 1);

        configure(0, 32'hF_FFFF, 32'hF_FFFF, CODE_MAX, CODE_MAX, 32'hFFFF, 0);
        send_sample(CODE_MAX, CODE_MAX);
        send_sample(0, 0);
        send_sample(CODE_MAX, 0);

        configure(1000, 0, 0, 0, 0, 0, 1);
        send_sample(0, 0);
        send_sample(1, 0);
        send_sample(0, 1);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            send_idle = (seg < 3) ? 36 : (seg < 6) ? 76 : 0;
            recv_idle = (seg < 3) ? 76 : (seg < 6) ? 36 : 0;
            configure(($urandom_range(3) == 0) ? pick(CUR_MAX) : $urandom_range(300000),
                      pick(32'hF_FFFF), pick(32'hF_FFFF), pick(CODE_MAX), pick(CODE_MAX),
                      ($urandom_range(3) == 0) ? pick(32'hFFFF) : $urandom_range(400),
                      ($urandom_range(3) == 0) ? pick(1023) : $urandom_range(1, 1023));
            repeat (SEG_ITEMS) send_random();
        end
        settle();

        $display("Checked %0d loop ticks, %0d on the amplified path, over %0d register settings,",
                 tracker.checked, tracker.amp_ticks, settings);
        $display("with sender and receiver stalls swept from heavy to none.");
        if (tracker.errors == 0 && tracker.pending_ticks.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### current_limit_duty_loop_core.f
+incdir+rtl/core
rtl/core/clcl_pkg.sv
rtl/core/clcl_if.sv
rtl/core/clcl_front.sv
rtl/core/clcl_queue.sv
rtl/core/clcl_back.sv
rtl/core/current_limit_duty_loop_core.sv
rtl/core/clcl_checker.sv
sim/tb_current_limit_duty_loop_core.sv
